[design/wsp_pkg.sv]
package wsp_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_HDR   = 4'd3,
        PH_FMT   = 4'd4,
        PH_DATA  = 4'd5,
        PH_SKIP  = 4'd6,
        PH_PAD   = 4'd7,
        PH_HALT  = 4'd8
    } phase_t;

    // Result item kinds.
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // Status codes carried by error and end items.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_RIFF    = 3'd1,
        ST_NOT_WAVE    = 3'd2,
        ST_NOT_PCM     = 3'd3,
        ST_ZERO_CHAN   = 3'd4,
        ST_BAD_BITS    = 3'd5,
        ST_MISSING_FMT = 3'd6
    } status_t;

    // Chunk tags as they appear after four little-endian byte shifts.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Sign flip that turns offset-binary 8-bit samples into two's complement.
    localparam logic [31:0] OFFSET_BIN_FLIP = 32'h8000_0000;

    // PCM format code.
    localparam logic [15:0] FMT_PCM = 16'd1;

    // Depth of the result queue; must be a power of two and at least 4.
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [15:0]        channel;
        logic               frame_end;
        logic signed [31:0] sample;
        logic [15:0]        num_channels;
        logic [31:0]        sample_rate;
        logic [15:0]        bits_per_sample;
        logic               last;
    } out_item_t;

    // Results produced by one accepted byte: zero, one or two items.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  item0;
        out_item_t  item1;
    } out_push_t;

endpackage

[design/wav_stream_parser_top.sv]
// WAV stream parser.
// Input channel (in_valid/in_ready/in_data) takes one byte of a RIFF/WAVE file
// per item, with first_byte marking the start of a file and last_byte its end.
// Output channel (out_valid/out_ready/out_data) delivers result items: PCM
// samples as left-justified signed Q1.31, a format report when the fmt chunk
// ends, an error item when the header is bad, and an end-of-file item after
// the byte marked last_byte. A byte causes zero, one or two result items.
// Each accepted byte is parsed in the cycle it is accepted and its results are
// written into a four-entry result queue, so an empty queue shows the first
// result in the cycle after acceptance. One byte is accepted per cycle while
// the queue has room for two more items; a byte that causes two results takes
// two queue entries, and ordinary sample data sustains one byte per cycle
// while the receiver keeps up. When the receiver stalls, the queue fills and
// in_ready drops until room for two items is free again; nothing is lost.
// Reset clears the parser to expect a RIFF tag and empties the queue.
// After an error the parser ignores bytes until the next first_byte or
// last_byte mark.
module wav_stream_parser_top
    import wsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    phase_t      phase_reg,      phase_next;
    logic [2:0]  field_pos_reg,  field_pos_next;
    logic [4:0]  fmt_off_reg,    fmt_off_next;
    logic [31:0] tag_reg,        tag_next;
    logic [31:0] chunk_len_reg,  chunk_len_next;
    logic [31:0] remain_reg,     remain_next;
    logic [15:0] format_reg,     format_next;
    logic [15:0] chan_total_reg, chan_total_next;
    logic [31:0] rate_reg,       rate_next;
    logic [15:0] width_reg,      width_next;
    logic        fmt_seen_reg,   fmt_seen_next;
    logic [31:0] smp_shift_reg,  smp_shift_next;
    logic [1:0]  smp_idx_reg,    smp_idx_next;
    logic [15:0] chan_cnt_reg,   chan_cnt_next;
    status_t     err_reg,        err_next;

    logic        in_fire;
    logic        has_room;
    out_push_t   push;

    assign in_ready = has_room;
    assign in_fire  = in_valid & in_ready;

    // One byte of parsing: state update and up to two result items.
    always_comb
    begin
        logic [7:0]  b;
        logic        fmt_end;
        logic        body_end;
        logic [2:0]  bps;
        logic [2:0]  idx_inc;
        logic        fe;
        logic [31:0] smp;
        out_item_t   r;

        b        = in_data.data_byte;
        fmt_end  = 1'b0;
        body_end = 1'b0;
        bps      = 3'd1;
        idx_inc  = 3'd0;
        fe       = 1'b0;
        smp      = '0;
        r        = '0;

        phase_next      = phase_reg;
        field_pos_next  = field_pos_reg;
        fmt_off_next    = fmt_off_reg;
        tag_next        = tag_reg;
        chunk_len_next  = chunk_len_reg;
        remain_next     = remain_reg;
        format_next     = format_reg;
        chan_total_next = chan_total_reg;
        rate_next       = rate_reg;
        width_next      = width_reg;
        fmt_seen_next   = fmt_seen_reg;
        smp_shift_next  = smp_shift_reg;
        smp_idx_next    = smp_idx_reg;
        chan_cnt_next   = chan_cnt_reg;
        err_next        = err_reg;
        push            = '0;

        if (in_fire)
        begin
            // A new file restarts the parser before its first byte.
            if (in_data.first_byte)
            begin
                phase_next      = PH_RIFF;
                field_pos_next  = '0;
                fmt_off_next    = '0;
                tag_next        = '0;
                chunk_len_next  = '0;
                remain_next     = '0;
                format_next     = FMT_PCM;
                chan_total_next = '0;
                rate_next       = '0;
                width_next      = '0;
                fmt_seen_next   = 1'b0;
                smp_shift_next  = '0;
                smp_idx_next    = '0;
                chan_cnt_next   = '0;
                err_next        = ST_OK;
            end

            case (phase_next)
                PH_RIFF, PH_WAVE:
                begin
                    tag_next = {b, tag_next[31:8]};
                    if (field_pos_next == 3'd3)
                    begin
                        field_pos_next = '0;
                        if (phase_next == PH_RIFF)
                        begin
                            if (tag_next != TAG_RIFF)
                            begin
                                err_next   = ST_NOT_RIFF;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                phase_next = PH_RSIZE;
                            end
                        end
                        else
                        begin
                            if (tag_next != TAG_WAVE)
                            begin
                                err_next   = ST_NOT_WAVE;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                phase_next = PH_HDR;
                            end
                        end
                        if (phase_next == PH_HALT)
                        begin
                            r        = '0;
                            r.kind   = KIND_ERROR;
                            r.status = err_next;
                            push.item0 = r;
                            push.count = 2'd1;
                        end
                    end
                    else
                    begin
                        field_pos_next = field_pos_next + 3'd1;
                    end
                end
                PH_RSIZE:
                begin
                    // The RIFF size is not needed; only its four bytes are counted.
                    if (field_pos_next == 3'd3)
                    begin
                        field_pos_next = '0;
                        phase_next     = PH_WAVE;
                    end
                    else
                    begin
                        field_pos_next = field_pos_next + 3'd1;
                    end
                end
                PH_HDR:
                begin
                    if (!field_pos_next[2])
                    begin
                        tag_next = {b, tag_next[31:8]};
                    end
                    else
                    begin
                        chunk_len_next = {b, chunk_len_next[31:8]};
                    end
                    if (field_pos_next == 3'd7)
                    begin
                        field_pos_next = '0;
                        remain_next    = chunk_len_next;
                        if (tag_next == TAG_FMT)
                        begin
                            phase_next   = PH_FMT;
                            fmt_off_next = '0;
                            fmt_end      = (chunk_len_next == '0);
                        end
                        else if (tag_next == TAG_DATA)
                        begin
                            if (!fmt_seen_next)
                            begin
                                err_next   = ST_MISSING_FMT;
                                phase_next = PH_HALT;
                                r          = '0;
                                r.kind     = KIND_ERROR;
                                r.status   = ST_MISSING_FMT;
                                push.item0 = r;
                                push.count = 2'd1;
                            end
                            else
                            begin
                                phase_next     = PH_DATA;
                                smp_shift_next = '0;
                                smp_idx_next   = '0;
                                chan_cnt_next  = '0;
                                body_end       = (chunk_len_next == '0);
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                            body_end   = (chunk_len_next == '0);
                        end
                    end
                    else
                    begin
                        field_pos_next = field_pos_next + 3'd1;
                    end
                end
                PH_FMT:
                begin
                    // Capture the fields at fixed offsets; the offset saturates past 15.
                    if (!fmt_off_next[4])
                    begin
                        case (fmt_off_next[3:0])
                            4'd0:    format_next[7:0]      = b;
                            4'd1:    format_next[15:8]     = b;
                            4'd2:    chan_total_next[7:0]  = b;
                            4'd3:    chan_total_next[15:8] = b;
                            4'd4:    rate_next[7:0]        = b;
                            4'd5:    rate_next[15:8]       = b;
                            4'd6:    rate_next[23:16]      = b;
                            4'd7:    rate_next[31:24]      = b;
                            4'd14:   width_next[7:0]       = b;
                            4'd15:   width_next[15:8]      = b;
                            default: ;
                        endcase
                        fmt_off_next = fmt_off_next + 5'd1;
                    end
                    fmt_end     = (remain_next == 32'd1);
                    remain_next = remain_next - 32'd1;
                end
                PH_DATA:
                begin
                    // Bytes per sample, clamped to one through four.
                    if (width_next[15:5] != '0)
                    begin
                        bps = 3'd4;
                    end
                    else if (width_next[4:3] == 2'd0)
                    begin
                        bps = 3'd1;
                    end
                    else
                    begin
                        bps = {1'b0, width_next[4:3]};
                    end
                    smp_shift_next = {b, smp_shift_next[31:8]};
                    idx_inc        = {1'b0, smp_idx_next} + 3'd1;
                    if (idx_inc >= bps)
                    begin
                        smp = smp_shift_next;
                        if (bps == 3'd1)
                        begin
                            smp = smp ^ OFFSET_BIN_FLIP;
                        end
                        fe = ({1'b0, chan_cnt_next} + 17'd1) >= {1'b0, chan_total_next};
                        r           = '0;
                        r.kind      = KIND_SAMPLE;
                        r.channel   = chan_cnt_next;
                        r.frame_end = fe;
                        r.sample    = smp;
                        push.item0  = r;
                        push.count  = 2'd1;
                        chan_cnt_next  = fe ? '0 : chan_cnt_next + 16'd1;
                        smp_shift_next = '0;
                        smp_idx_next   = '0;
                    end
                    else
                    begin
                        smp_idx_next = idx_inc[1:0];
                    end
                    body_end    = (remain_next == 32'd1);
                    remain_next = remain_next - 32'd1;
                end
                PH_SKIP:
                begin
                    body_end    = (remain_next == 32'd1);
                    remain_next = remain_next - 32'd1;
                end
                PH_PAD:
                begin
                    phase_next = PH_HDR;
                end
                default: ;
            endcase

            // End of the fmt chunk: checks in order, then an error item or the format report.
            if (fmt_end)
            begin
                r      = '0;
                r.kind = KIND_ERROR;
                if (format_next != FMT_PCM)
                begin
                    err_next = ST_NOT_PCM;
                end
                else if (chan_total_next == '0)
                begin
                    err_next = ST_ZERO_CHAN;
                end
                else if (!(width_next inside {16'd8, 16'd16, 16'd24, 16'd32}))
                begin
                    err_next = ST_BAD_BITS;
                end
                if (err_next != ST_OK)
                begin
                    phase_next = PH_HALT;
                    r.status   = err_next;
                end
                else
                begin
                    fmt_seen_next = 1'b1;
                    r.kind        = KIND_FORMAT;
                    body_end      = 1'b1;
                end
                push.item0 = r;
                push.count = 2'd1;
            end

            // End of a chunk body: a pad byte follows an odd length.
            if (body_end)
            begin
                phase_next = chunk_len_next[0] ? PH_PAD : PH_HDR;
            end

            // End-of-file item follows any result of this byte.
            if (in_data.last_byte)
            begin
                r      = '0;
                r.kind = KIND_END;
                if (err_next != ST_OK)
                begin
                    r.status = err_next;
                end
                else if (!fmt_seen_next)
                begin
                    r.status = ST_MISSING_FMT;
                end
                if (push.count == 2'd0)
                begin
                    push.item0 = r;
                    push.count = 2'd1;
                end
                else
                begin
                    push.item1 = r;
                    push.count = 2'd2;
                end
            end

            // Held fmt values go into every item; the final item is marked.
            push.item0.num_channels    = chan_total_next;
            push.item0.sample_rate     = rate_next;
            push.item0.bits_per_sample = width_next;
            push.item1.num_channels    = chan_total_next;
            push.item1.sample_rate     = rate_next;
            push.item1.bits_per_sample = width_next;
            push.item0.last            = (push.count == 2'd1);
            push.item1.last            = (push.count == 2'd2);

            // The parser returns to its reset state after the last byte.
            if (in_data.last_byte)
            begin
                phase_next      = PH_RIFF;
                field_pos_next  = '0;
                fmt_off_next    = '0;
                tag_next        = '0;
                chunk_len_next  = '0;
                remain_next     = '0;
                format_next     = FMT_PCM;
                chan_total_next = '0;
                rate_next       = '0;
                width_next      = '0;
                fmt_seen_next   = 1'b0;
                smp_shift_next  = '0;
                smp_idx_next    = '0;
                chan_cnt_next   = '0;
                err_next        = ST_OK;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RIFF;
            field_pos_reg  <= '0;
            fmt_off_reg    <= '0;
            tag_reg        <= '0;
            chunk_len_reg  <= '0;
            remain_reg     <= '0;
            format_reg     <= FMT_PCM;
            chan_total_reg <= '0;
            rate_reg       <= '0;
            width_reg      <= '0;
            fmt_seen_reg   <= 1'b0;
            smp_shift_reg  <= '0;
            smp_idx_reg    <= '0;
            chan_cnt_reg   <= '0;
            err_reg        <= ST_OK;
        end
        else
        begin
            phase_reg      <= phase_next;
            field_pos_reg  <= field_pos_next;
            fmt_off_reg    <= fmt_off_next;
            tag_reg        <= tag_next;
            chunk_len_reg  <= chunk_len_next;
            remain_reg     <= remain_next;
            format_reg     <= format_next;
            chan_total_reg <= chan_total_next;
            rate_reg       <= rate_next;
            width_reg      <= width_next;
            fmt_seen_reg   <= fmt_seen_next;
            smp_shift_reg  <= smp_shift_next;
            smp_idx_reg    <= smp_idx_next;
            chan_cnt_reg   <= chan_cnt_next;
            err_reg        <= err_next;
        end
    end

    // Result queue between the parser and the output channel.
    wsp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[design/wsp_out_fifo.sv]
module wsp_out_fifo
    import wsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  out_push_t push,
    output logic      has_room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int PtrW = $clog2(OUT_DEPTH);
    localparam int CntW = PtrW + 1;

    out_item_t         mem_reg [OUT_DEPTH];
    logic [PtrW-1:0]   head_reg;
    logic [PtrW-1:0]   head_next;
    logic [PtrW-1:0]   tail_reg;
    logic [PtrW-1:0]   tail_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              pop;

    // The head entry is presented whenever the queue holds anything.
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[head_reg];
    assign pop       = out_valid & out_ready;

    // Room for the worst case of two items from the next byte.
    assign has_room  = (count_reg <= CntW'(OUT_DEPTH - 2));

    // Pointer and occupancy updates.
    always_comb
    begin
        head_next  = pop ? head_reg + PtrW'(1) : head_reg;
        tail_next  = tail_reg + PtrW'(push.count);
        count_next = count_reg + CntW'(push.count) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Item storage; the second item of a byte lands behind the first.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.item0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_reg + PtrW'(1)] <= push.item1;
        end
    end

endmodule

[tb/sv/wav_stream_parser_top_test.sv]
module wav_stream_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    // Tracks the parser's state for every accepted byte and holds the result
    // items that the byte should cause, oldest first.
    class wav_result_tracker;
        phase_t      phase;
        int          pos;
        logic [31:0] tag_shift;
        logic [31:0] chunk_len;
        logic [31:0] remaining;
        logic [31:0] size_shift;
        logic [15:0] fmt_code;
        logic [15:0] chan_total;
        logic [31:0] rate;
        logic [15:0] bits;
        bit          fmt_ok;
        logic [31:0] smp_shift;
        int          smp_idx;
        logic [15:0] chan_cnt;
        status_t     err;
        out_item_t   expected_results[$];
        int          failures;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase      = PH_RIFF;
            pos        = 0;
            tag_shift  = '0;
            chunk_len  = '0;
            remaining  = '0;
            size_shift = '0;
            fmt_code   = FMT_PCM;
            chan_total = '0;
            rate       = '0;
            bits       = '0;
            fmt_ok     = 1'b0;
            smp_shift  = '0;
            smp_idx    = 0;
            chan_cnt   = '0;
            err        = ST_OK;
        endfunction

        // Every result carries the fmt values held at the moment it is made.
        function void push_result(kind_t k, status_t s, logic [15:0] ch, logic fe,
                                  logic [31:0] smp);
            out_item_t r;
            r                 = '0;
            r.kind            = k;
            r.status          = s;
            r.channel         = ch;
            r.frame_end       = fe;
            r.sample          = smp;
            r.num_channels    = chan_total;
            r.sample_rate     = rate;
            r.bits_per_sample = bits;
            r.last            = 1'b0;
            expected_results.push_back(r);
        endfunction

        function void raise(status_t s);
            err   = s;
            phase = PH_HALT;
            push_result(KIND_ERROR, s, '0, 1'b0, '0);
        endfunction

        // An odd-length chunk is followed by one pad byte.
        function void body_done();
            phase = chunk_len[0] ? PH_PAD : PH_HDR;
        endfunction

        function void fmt_finish();
            if (fmt_code != FMT_PCM)
                raise(ST_NOT_PCM);
            else if (chan_total == 16'd0)
                raise(ST_ZERO_CHAN);
            else if (bits != 16'd8 && bits != 16'd16 && bits != 16'd24 && bits != 16'd32)
                raise(ST_BAD_BITS);
            else
            begin
                fmt_ok = 1'b1;
                push_result(KIND_FORMAT, ST_OK, '0, 1'b0, '0);
                body_done();
            end
        endfunction

        function void capture_fmt(logic [31:0] offset, logic [7:0] b);
            case (offset)
                0:  fmt_code[7:0]    = b;
                1:  fmt_code[15:8]   = b;
                2:  chan_total[7:0]  = b;
                3:  chan_total[15:8] = b;
                4:  rate[7:0]        = b;
                5:  rate[15:8]       = b;
                6:  rate[23:16]      = b;
                7:  rate[31:24]      = b;
                14: bits[7:0]        = b;
                15: bits[15:8]       = b;
                default: ;
            endcase
        endfunction

        // Advances the parser by one accepted byte.
        function void note_byte(in_item_t item);
            int          start_count;
            int          bps;
            bit          fe;
            logic [7:0]  b;
            logic [31:0] v;
            out_item_t   tail;
            start_count = expected_results.size();
            b           = item.data_byte;
            if (item.first_byte)
                clear_state();
            case (phase)
                PH_RIFF, PH_WAVE:
                begin
                    tag_shift = {b, tag_shift[31:8]};
                    pos++;
                    if (pos >= 4)
                    begin
                        pos = 0;
                        if (phase == PH_RIFF)
                        begin
                            if (tag_shift != TAG_RIFF)
                                raise(ST_NOT_RIFF);
                            else
                                phase = PH_RSIZE;
                        end
                        else
                        begin
                            if (tag_shift != TAG_WAVE)
                                raise(ST_NOT_WAVE);
                            else
                                phase = PH_HDR;
                        end
                    end
                end
                PH_RSIZE:
                begin
                    size_shift = {b, size_shift[31:8]};
                    pos++;
                    if (pos >= 4)
                    begin
                        pos   = 0;
                        phase = PH_WAVE;
                    end
                end
                PH_HDR:
                begin
                    if (pos < 4)
                        tag_shift = {b, tag_shift[31:8]};
                    else
                        chunk_len = {b, chunk_len[31:8]};
                    pos++;
                    if (pos >= 8)
                    begin
                        pos       = 0;
                        remaining = chunk_len;
                        if (tag_shift == TAG_FMT)
                        begin
                            phase = PH_FMT;
                            if (chunk_len == 0)
                                fmt_finish();
                        end
                        else if (tag_shift == TAG_DATA)
                        begin
                            if (!fmt_ok)
                                raise(ST_MISSING_FMT);
                            else
                            begin
                                phase     = PH_DATA;
                                smp_shift = '0;
                                smp_idx   = 0;
                                chan_cnt  = '0;
                                if (chunk_len == 0)
                                    body_done();
                            end
                        end
                        else
                        begin
                            phase = PH_SKIP;
                            if (chunk_len == 0)
                                body_done();
                        end
                    end
                end
                PH_FMT:
                begin
                    capture_fmt(chunk_len - remaining, b);
                    remaining--;
                    if (remaining == 0)
                        fmt_finish();
                end
                PH_DATA:
                begin
                    bps = int'(bits >> 3);
                    if (bps < 1)
                        bps = 1;
                    if (bps > 4)
                        bps = 4;
                    smp_shift = {b, smp_shift[31:8]};
                    smp_idx++;
                    if (smp_idx >= bps)
                    begin
                        v  = smp_shift;
                        fe = (int'(chan_cnt) + 1 >= int'(chan_total));
                        // 8-bit PCM is offset binary.
                        if (bps == 1)
                            v = v ^ OFFSET_BIN_FLIP;
                        push_result(KIND_SAMPLE, ST_OK, chan_cnt, fe, v);
                        chan_cnt  = fe ? 16'd0 : chan_cnt + 16'd1;
                        smp_shift = '0;
                        smp_idx   = 0;
                    end
                    remaining--;
                    if (remaining == 0)
                        body_done();
                end
                PH_SKIP:
                begin
                    remaining--;
                    if (remaining == 0)
                        body_done();
                end
                PH_PAD:
                    phase = PH_HDR;
                default: ;
            endcase

            // The end report goes after whatever this byte produced.
            if (item.last_byte)
            begin
                push_result(KIND_END,
                            (err != ST_OK) ? err : (fmt_ok ? ST_OK : ST_MISSING_FMT),
                            '0, 1'b0, '0);
                clear_state();
            end
            if (expected_results.size() > start_count)
            begin
                tail      = expected_results.pop_back();
                tail.last = 1'b1;
                expected_results.push_back(tail);
            end
        endfunction

        function bit differs(string name, logic [31:0] want, logic [31:0] seen);
            if (want === seen)
                return 1'b0;
            if (failures < 10)
                $display("  %s: expected %0h, got %0h", name, want, seen);
            return 1'b1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            bit        bad;
            if (expected_results.size() == 0)
            begin
                if (failures < 10)
                    $display("%0t: result item with none expected, kind %0d",
                             $time, got.kind);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got !== want && failures < 10)
                $display("%0t: result mismatch", $time);
            bad = differs("kind", want.kind, got.kind)
                | differs("status", want.status, got.status)
                | differs("channel", want.channel, got.channel)
                | differs("frame_end", want.frame_end, got.frame_end)
                | differs("sample", want.sample, got.sample)
                | differs("num_channels", want.num_channels, got.num_channels)
                | differs("sample_rate", want.sample_rate, got.sample_rate)
                | differs("bits_per_sample", want.bits_per_sample, got.bits_per_sample)
                | differs("last", want.last, got.last);
            if (bad)
                failures++;
        endfunction
    endclass

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    wav_result_tracker tracker = new();
    logic [7:0]        file_bytes[$];
    int                sent_bytes = 0;
    int                burst_left = 0;
    int                cycle_count = 0;
    ready_mode_t       ready_mode = READY_ALWAYS;
    int                ready_tick = 0;

    wav_stream_parser_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: checks each accepted result item and stalls in a randomly chosen
    // mode that is picked anew whenever its tick counter runs out.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            tracker.check_result(out_data);
        if (ready_tick == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_tick = 300;
        end
        ready_tick--;
        case (ready_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            default:        out_ready <= ((ready_tick % 8) < 3);
        endcase
    end

    function automatic void put32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(v[8 * i +: 8]);
    endfunction

    // Sample bytes lean toward the values at the ends of the range.
    function automatic logic [7:0] sample_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_fmt_chunk();
        logic [15:0]  code;
        logic [15:0]  chans;
        logic [15:0]  width;
        logic [31:0]  sps;
        logic [31:0]  len;
        logic [159:0] image;
        code = ($urandom_range(0, 11) == 0) ? 16'($urandom) : FMT_PCM;
        case ($urandom_range(0, 19))
            0:                      chans = 16'd0;
            1:                      chans = 16'hFFFF;
            2:                      chans = 16'($urandom);
            3, 4, 5, 6, 7, 8, 9:    chans = 16'd1;
            10, 11, 12, 13, 14, 15: chans = 16'd2;
            default:                chans = 16'($urandom_range(3, 6));
        endcase
        case ($urandom_range(0, 19))
            0:       width = 16'($urandom);
            1:       width = 16'd12;
            default: width = 16'(8 * $urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       sps = 32'd0;
            1:       sps = 32'hFFFF_FFFF;
            default: sps = $urandom;
        endcase
        // Short and long fmt chunks appear now and then.
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(0, 15);
            1:       len = 32'd18;
            2:       len = 32'd20;
            default: len = 32'd16;
        endcase
        image = {32'($urandom), width, 16'($urandom), 32'($urandom), sps, chans, code};
        put32(TAG_FMT);
        put32(len);
        for (int i = 0; i < len; i++)
            file_bytes.push_back(image[8 * i +: 8]);
        if (len[0])
            file_bytes.push_back(8'($urandom));
    endfunction

    // Data or unknown chunk. Returns 1 when the chunk claims the largest
    // length and so runs to the end of the file.
    function automatic bit add_body_chunk(logic [31:0] tag, int max_len);
        bit          open_end;
        logic [31:0] len;
        int          fill;
        open_end = ($urandom_range(0, 19) == 0);
        len      = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, max_len);
        fill     = open_end ? $urandom_range(1, 30) : int'(len);
        put32(tag);
        put32(open_end ? 32'hFFFF_FFFF : len);
        for (int i = 0; i < fill; i++)
            file_bytes.push_back(sample_byte());
        if (!open_end && len[0])
            file_bytes.push_back(8'($urandom));
        return open_end;
    endfunction

    // Mostly well-formed files with random content; some have bad tags,
    // data before fmt, truncation or trailing noise.
    function automatic void build_random_file();
        int chunk_total;
        int pick;
        bit fmt_placed;
        bit stop;
        int cut;
        file_bytes.delete();
        fmt_placed = 1'b0;
        stop       = 1'b0;
        put32(($urandom_range(0, 19) == 0) ? (TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)))
                                           : TAG_RIFF);
        put32($urandom);
        put32(($urandom_range(0, 19) == 0) ? (TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)))
                                           : TAG_WAVE);
        chunk_total = $urandom_range(2, 5);
        for (int c = 0; c < chunk_total && !stop; c++)
        begin
            pick = $urandom_range(0, 99);
            if (fmt_placed ? (pick >= 85) : (pick < 70))
            begin
                add_fmt_chunk();
                fmt_placed = 1'b1;
            end
            else if (fmt_placed ? (pick < 65) : (pick >= 85))
                stop = add_body_chunk(TAG_DATA, 40);
            else
                stop = add_body_chunk($urandom, 7);
        end
        if ($urandom_range(0, 11) == 0)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 4))
                file_bytes.push_back(8'($urandom));
    endfunction

    // Offers one item, with a random gap at the start of each burst, and waits
    // for it to be accepted.
    task automatic send_byte(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_byte(item);
        sent_bytes++;
    endtask

    // Sends the built file; stray first and last marks land inside it rarely.
    task automatic send_file(input bit mark_first, input bit mark_last);
        in_item_t item;
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            item.data_byte  = file_bytes[i];
            item.first_byte = (i == 0 && mark_first) || ($urandom_range(0, 199) == 0);
            item.last_byte  = (i == file_bytes.size() - 1 && mark_last)
                              || ($urandom_range(0, 199) == 0);
            send_byte(item);
        end
    endtask

    // Holds the sender off until every expected result item has arrived.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.expected_results.size() != 0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Wrong RIFF tag: error on the fourth byte, then the end report.
        file_bytes.delete();
        put32(TAG_RIFF ^ 32'h0100_0000);
        send_file(1'b1, 1'b1);

        // One byte marked both first and last: end report with missing fmt.
        file_bytes.delete();
        file_bytes.push_back(8'h52);
        send_file(1'b1, 1'b1);

        // Empty fmt chunk leaves zero channels; the last byte yields two items.
        file_bytes.delete();
        put32(TAG_RIFF);
        put32(32'hFFFF_FFFF);
        put32(TAG_WAVE);
        put32(TAG_FMT);
        put32(32'd0);
        send_file(1'b1, 1'b1);

        wait_for_results();

        // Random files until enough bytes have been sent.
        while (sent_bytes < ITEM_TARGET)
        begin
            build_random_file();
            send_file($urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
            if ($urandom_range(0, 15) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (tracker.failures == 0 && tracker.expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
